// ===== hdl/psh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psh_pkg
// Shared types and constants for the program counter sampling histogram:
// field widths, register indexes, operation codes and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package psh_pkg;

    localparam int PC_W        = 32;
    localparam int CNT_W       = 32;
    localparam int READ_BIN_W  = 12;
    localparam int BINS_CFG_W  = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = 5;

    localparam logic [CFG_DATA_W-1:0] GRAN_RESET = 32'd16;
    localparam logic [BINS_CFG_W-1:0] BINS_RESET = 13'd4096;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE = 2'd0,
        REG_GRAN = 2'd1,
        REG_BINS = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic div_step;
        logic count_record;
        logic latch_value;
        logic mem_write;
        logic load_result;
    } psh_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic is_read;
        logic in_range;
        logic out_free;
    } psh_status_t;

endpackage
`default_nettype wire

// ===== hdl/psh_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psh_if
// Valid/ready channels of the histogram: sample words in, result words out.
// ----------------------------------------------------------------------------
interface psh_sample_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [psh_pkg::PC_W-1:0]            sampled_pc;
    logic [psh_pkg::READ_BIN_W-1:0]      read_bin;

    modport source (output valid, output operation, output sampled_pc,
                    output read_bin, input ready);
    modport sink   (input valid, input operation, input sampled_pc,
                    input read_bin, output ready);
endinterface

interface psh_result_if;
    logic                                valid;
    logic                                ready;
    logic [psh_pkg::CNT_W-1:0]           bin_value;
    logic [psh_pkg::CNT_W-1:0]           total_samples;
    logic [psh_pkg::CNT_W-1:0]           stray_samples;
    logic                                was_stray;

    modport source (output valid, output bin_value, output total_samples,
                    output stray_samples, output was_stray, input ready);
    modport sink   (input valid, input bin_value, input total_samples,
                    input stray_samples, input was_stray, output ready);
endinterface
`default_nettype wire

// ===== hdl/psh_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psh_ram
// Generic single-port RAM with one address per cycle and a registered read.
// ----------------------------------------------------------------------------
module psh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [ADDR_W-1:0]       addr,
    input  wire logic [WIDTH-1:0]        wdata,
    output logic      [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hdl/psh_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psh_ctrl
// Controller: clearing pass after reset, then one word at a time through
// divide and range check (records), bin read or read-modify-write, result load.
// ----------------------------------------------------------------------------
module psh_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    input  wire logic                  sample_operation,
    output logic                       sample_ready,
    input  wire psh_pkg::psh_status_t  status,
    output psh_pkg::psh_cmd_t          cmd
);
    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DIV    = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_READ   = 7'b0010000,
        S_UPDATE = 7'b0100000,
        S_RESP   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        sample_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (sample_operation == psh_pkg::OP_READ) ? S_READ : S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.count_record = 1'b1;
                state_next       = status.in_range ? S_READ : S_RESP;
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.latch_value = 1'b1;
                cmd.mem_write   = !status.is_read;
                state_next      = S_RESP;
            end
            S_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_check_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> $past(state_reg) == S_DIV)
        else $error("Range check entered without a finished divide.");

    a_write_only_record: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_write |-> $past(state_reg) == S_READ && !status.is_read)
        else $error("Bin write outside a record read-modify-write.");
`endif

endmodule
`default_nettype wire

// ===== hdl/psh_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psh_datapath
// Datapath of the histogram: configuration registers, restoring divider,
// bin memory with its clearing counter, sample counters and result register.
// ----------------------------------------------------------------------------
module psh_datapath #(
    parameter int NUM_BINS = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [psh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [psh_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                operation,
    input  wire logic [psh_pkg::PC_W-1:0]            sampled_pc,
    input  wire logic [psh_pkg::READ_BIN_W-1:0]      read_bin,
    input  wire psh_pkg::psh_cmd_t                   cmd,
    output psh_pkg::psh_status_t                     status,
    psh_result_if.source                             result
);
    localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int EXT_W = (BIN_W > psh_pkg::READ_BIN_W) ? BIN_W : psh_pkg::READ_BIN_W;
    localparam logic [psh_pkg::CNT_W-1:0] NUM_BINS_W = psh_pkg::CNT_W'(NUM_BINS);
    localparam logic [BIN_W-1:0]          LAST_BIN   = BIN_W'(NUM_BINS - 1);

    logic [psh_pkg::PC_W-1:0]        base_reg;
    logic [psh_pkg::CFG_DATA_W-1:0]  gran_reg;
    logic [psh_pkg::BINS_CFG_W-1:0]  bins_reg;
    logic [BIN_W-1:0]                clr_addr_reg;
    logic [psh_pkg::DIV_CNT_W-1:0]   step_reg;
    logic [psh_pkg::CNT_W-1:0]       sample_total_reg;
    logic [psh_pkg::CNT_W-1:0]       stray_total_reg;
    logic                            out_valid_reg;

    logic                            op_reg;
    logic [psh_pkg::PC_W-1:0]        quo_reg;
    logic [psh_pkg::PC_W-1:0]        rem_reg;
    logic [psh_pkg::READ_BIN_W-1:0]  read_bin_reg;
    logic                            stray_reg;
    logic [psh_pkg::CNT_W-1:0]       value_reg;
    logic [psh_pkg::CNT_W-1:0]       out_bin_reg;
    logic [psh_pkg::CNT_W-1:0]       out_total_reg;
    logic [psh_pkg::CNT_W-1:0]       out_stray_reg;
    logic                            out_was_stray_reg;

    logic [psh_pkg::PC_W:0]          shifted;
    logic [psh_pkg::PC_W:0]          diff;
    logic                            ge;
    logic [psh_pkg::CNT_W-1:0]       bins_ext;
    logic [psh_pkg::CNT_W-1:0]       limit;
    logic                            read_ok;
    logic [EXT_W-1:0]                read_ext;
    logic [BIN_W-1:0]                item_idx;
    logic [BIN_W-1:0]                mem_addr;
    logic                            mem_we;
    logic [psh_pkg::CNT_W-1:0]       mem_wdata;
    logic [psh_pkg::CNT_W-1:0]       mem_rdata;
    logic [psh_pkg::CNT_W-1:0]       bumped;

    assign shifted  = {rem_reg, quo_reg[psh_pkg::PC_W-1]};
    assign diff     = shifted - {1'b0, gran_reg};
    assign ge       = shifted >= {1'b0, gran_reg};

    assign bins_ext = psh_pkg::CNT_W'(bins_reg);
    assign limit    = (bins_ext < NUM_BINS_W) ? bins_ext : NUM_BINS_W;
    assign read_ok  = psh_pkg::CNT_W'(read_bin_reg) < NUM_BINS_W;
    assign read_ext = EXT_W'(read_bin_reg);
    assign item_idx = (op_reg == psh_pkg::OP_READ) ? read_ext[BIN_W-1:0]
                                                   : quo_reg[BIN_W-1:0];
    assign mem_addr  = cmd.clear_step ? clr_addr_reg : item_idx;
    assign mem_we    = cmd.clear_step || cmd.mem_write;
    assign bumped    = mem_rdata + 32'd1;
    assign mem_wdata = cmd.clear_step ? '0 : bumped;

    assign status.clear_done = clr_addr_reg == LAST_BIN;
    assign status.div_done   = step_reg == psh_pkg::DIV_CNT_W'(psh_pkg::DIV_STEPS - 1);
    assign status.is_read    = op_reg == psh_pkg::OP_READ;
    assign status.in_range   = quo_reg < limit;
    assign status.out_free   = !out_valid_reg || result.ready;

    psh_ram #(
        .WIDTH (psh_pkg::CNT_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg         <= '0;
            gran_reg         <= psh_pkg::GRAN_RESET;
            bins_reg         <= psh_pkg::BINS_RESET;
            clr_addr_reg     <= '0;
            step_reg         <= '0;
            sample_total_reg <= '0;
            stray_total_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    psh_pkg::REG_BASE: base_reg <= cfg_data;
                    psh_pkg::REG_GRAN: gran_reg <= cfg_data;
                    psh_pkg::REG_BINS: bins_reg <= cfg_data[psh_pkg::BINS_CFG_W-1:0];
                    default:           base_reg <= base_reg;
                endcase
            end
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.load)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.count_record)
            begin
                sample_total_reg <= sample_total_reg + 32'd1;
                if (!status.in_range)
                begin
                    stray_total_reg <= stray_total_reg + 32'd1;
                end
            end
            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= operation;
            quo_reg      <= sampled_pc - base_reg;
            rem_reg      <= '0;
            read_bin_reg <= read_bin;
            stray_reg    <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? diff[psh_pkg::PC_W-1:0] : shifted[psh_pkg::PC_W-1:0];
            quo_reg <= {quo_reg[psh_pkg::PC_W-2:0], ge};
        end
        if (cmd.count_record)
        begin
            stray_reg <= !status.in_range;
            value_reg <= '0;
        end
        if (cmd.latch_value)
        begin
            if (op_reg == psh_pkg::OP_READ)
            begin
                value_reg <= read_ok ? mem_rdata : '0;
            end
            else
            begin
                value_reg <= bumped;
            end
        end
        if (cmd.load_result)
        begin
            out_bin_reg       <= value_reg;
            out_total_reg     <= sample_total_reg;
            out_stray_reg     <= stray_total_reg;
            out_was_stray_reg <= stray_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.bin_value     = out_bin_reg;
    assign result.total_samples = out_total_reg;
    assign result.stray_samples = out_stray_reg;
    assign result.was_stray     = out_was_stray_reg;

`ifndef SYNTHESIS
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_record |=> sample_total_reg == $past(sample_total_reg) + 32'd1)
        else $error("Sample total did not advance on a recorded sample.");

    a_stray_with_total: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(stray_total_reg) |-> !$stable(sample_total_reg))
        else $error("Stray total changed without a recorded sample.");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(out_total_reg))
        else $error("Pending result word was overwritten.");
`endif

endmodule
`default_nettype wire

// ===== hdl/pc_sample_histogram_top.sv =====
`default_nettype none
// Order: a record word in range passes through the 32 divide steps, the range
// check, the bin read, the bin write and the result load; a stray record skips
// the bin read and write, and a read word skips the divide and range check.
// Flow: one word at a time; a new word is taken once the last result is loaded.
// Divider: one quotient bit per cycle. Bin memory: a single port.
// Reset: counters and configuration return to their defaults, then a clearing
// pass zeroes every bin while sample.ready stays low.
// ----------------------------------------------------------------------------
// pc_sample_histogram_top
// Program counter sampling histogram: bins sampled addresses by offset and
// granularity, counts total and stray samples, and reads back single bins.
// ----------------------------------------------------------------------------
module pc_sample_histogram_top #(
    parameter int NUM_BINS = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [psh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [psh_pkg::CFG_DATA_W-1:0]    cfg_data,
    psh_sample_if.sink                             sample,
    psh_result_if.source                           result
);
    psh_pkg::psh_cmd_t    cmd;
    psh_pkg::psh_status_t status;

    psh_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (sample.valid),
        .sample_operation (sample.operation),
        .sample_ready     (sample.ready),
        .status           (status),
        .cmd              (cmd)
    );

    psh_datapath #(
        .NUM_BINS (NUM_BINS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .operation  (sample.operation),
        .sampled_pc (sample.sampled_pc),
        .read_bin   (sample.read_bin),
        .cmd        (cmd),
        .status     (status),
        .result     (result)
    );

endmodule
`default_nettype wire

// ===== sim/tb_pc_sample_histogram_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pc_sample_histogram_top
// Self-checking bench for the sampling histogram. A table of directed words
// and register writes covers reset state, address extremes and the stray
// corner cases. Several random phases with different configurations follow.
// Every result word is compared with the predicted count, bin and totals.
// ----------------------------------------------------------------------------
module tb_pc_sample_histogram_top;

    localparam int NUM_BINS     = 4096;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 8;
    localparam int END_TAIL     = 48;
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 96;
    localparam int N_DIRECTED   = 34;

    localparam logic [psh_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct packed {
        logic [psh_pkg::CNT_W-1:0] bin_value;
        logic [psh_pkg::CNT_W-1:0] total;
        logic [psh_pkg::CNT_W-1:0] stray;
        logic                      was_stray;
    } hist_result_t;

    typedef struct packed {
        logic                           is_cfg;
        logic [psh_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [psh_pkg::CFG_DATA_W-1:0] reg_data;
        logic                           op;
        logic [psh_pkg::PC_W-1:0]       pc;
        logic [psh_pkg::READ_BIN_W-1:0] rbin;
        logic                           typed;
        hist_result_t                   exp_result;
    } stim_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [psh_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [psh_pkg::CFG_DATA_W-1:0] cfg_data;

    psh_sample_if sample_ch ();
    psh_result_if result_ch ();

    pc_sample_histogram_top #(
        .NUM_BINS (NUM_BINS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    logic [psh_pkg::CNT_W-1:0]      bin_counts [NUM_BINS];
    logic [psh_pkg::CNT_W-1:0]      sample_count;
    logic [psh_pkg::CNT_W-1:0]      stray_count;
    logic [psh_pkg::PC_W-1:0]       cfg_base;
    logic [psh_pkg::CFG_DATA_W-1:0] cfg_gran;
    logic [psh_pkg::BINS_CFG_W-1:0] cfg_bin_limit;

    hist_result_t expected_results [$];
    stim_row_t    directed_rows [N_DIRECTED];

    bit          idle_on;
    int unsigned stall_left;
    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned words_sent;
    int unsigned reads_sent;
    int unsigned strays_seen;
    int unsigned results_checked;
    int unsigned cfg_writes;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic stim_row_t cfg_row(logic [psh_pkg::CFG_IDX_W-1:0] idx,
                                          logic [psh_pkg::CFG_DATA_W-1:0] data);
        stim_row_t row;
        row          = '0;
        row.is_cfg   = 1'b1;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    function automatic stim_row_t word_row(logic op, logic [psh_pkg::PC_W-1:0] pc,
                                           logic [psh_pkg::READ_BIN_W-1:0] rbin);
        stim_row_t row;
        row      = '0;
        row.op   = op;
        row.pc   = pc;
        row.rbin = rbin;
        return row;
    endfunction

    function automatic stim_row_t typed_row(logic op, logic [psh_pkg::PC_W-1:0] pc,
                                            logic [psh_pkg::READ_BIN_W-1:0] rbin,
                                            logic [psh_pkg::CNT_W-1:0] value,
                                            logic [psh_pkg::CNT_W-1:0] total,
                                            logic [psh_pkg::CNT_W-1:0] stray,
                                            logic was_stray);
        stim_row_t row;
        row            = word_row(op, pc, rbin);
        row.typed      = 1'b1;
        row.exp_result = '{value, total, stray, was_stray};
        return row;
    endfunction

    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic hist_result_t predict_word(logic op,
                                                  logic [psh_pkg::PC_W-1:0] pc,
                                                  logic [psh_pkg::READ_BIN_W-1:0] rbin);
        hist_result_t r;
        logic [psh_pkg::PC_W-1:0] offset;
        logic [psh_pkg::PC_W-1:0] bin_idx;
        logic [psh_pkg::PC_W-1:0] limit;
        r = '0;
        if (op == psh_pkg::OP_RECORD)
        begin
            offset  = pc - cfg_base;
            bin_idx = (cfg_gran == '0) ? '1 : offset / cfg_gran;
            limit   = (cfg_bin_limit > NUM_BINS) ? NUM_BINS : 32'(cfg_bin_limit);
            sample_count = sample_count + 1'b1;
            if (bin_idx < limit)
            begin
                bin_counts[bin_idx[psh_pkg::READ_BIN_W-1:0]] =
                    bin_counts[bin_idx[psh_pkg::READ_BIN_W-1:0]] + 1'b1;
                r.bin_value = bin_counts[bin_idx[psh_pkg::READ_BIN_W-1:0]];
            end
            else
            begin
                stray_count = stray_count + 1'b1;
                r.was_stray = 1'b1;
                strays_seen++;
            end
        end
        else
        begin
            r.bin_value = bin_counts[rbin];
        end
        r.total = sample_count;
        r.stray = stray_count;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH (result %0d): %s", results_checked, msg);
        error_count++;
    endtask

    task automatic send_word(input logic op, input logic [psh_pkg::PC_W-1:0] pc,
                             input logic [psh_pkg::READ_BIN_W-1:0] rbin,
                             input logic typed, input hist_result_t typed_result);
        int unsigned gap;
        hist_result_t predicted;
        gap = draw_gap();
        repeat (gap)
        begin
            @(negedge clk);
            sample_ch.valid <= 1'b0;
        end
        @(negedge clk);
        sample_ch.valid      <= 1'b1;
        sample_ch.operation  <= op;
        sample_ch.sampled_pc <= pc;
        sample_ch.read_bin   <= rbin;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        predicted = predict_word(op, pc, rbin);
        expected_results.push_back(typed ? typed_result : predicted);
        words_sent++;
        if (op == psh_pkg::OP_READ)
            reads_sent++;
    endtask

    task automatic quiesce();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [psh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [psh_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            psh_pkg::REG_BASE: cfg_base      = data;
            psh_pkg::REG_GRAN: cfg_gran      = data;
            psh_pkg::REG_BINS: cfg_bin_limit = data[psh_pkg::BINS_CFG_W-1:0];
            default:  ;
        endcase
        cfg_writes++;
    endtask

    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            stall_left = 0;
            result_ch.ready <= 1'b1;
        end
        else
        begin
            if (stall_left == 0)
                stall_left = draw_gap();
            result_ch.ready <= (stall_left == 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        hist_result_t got;
        hist_result_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got = '{result_ch.bin_value, result_ch.total_samples,
                    result_ch.stray_samples, result_ch.was_stray};
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result word with none expected, bin_value %0h",
                                          got.bin_value));
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.bin_value !== want.bin_value)
                    report_mismatch($sformatf("bin_value got %0h expected %0h",
                                              got.bin_value, want.bin_value));
                if (got.total !== want.total)
                    report_mismatch($sformatf("total_samples got %0h expected %0h",
                                              got.total, want.total));
                if (got.stray !== want.stray)
                    report_mismatch($sformatf("stray_samples got %0h expected %0h",
                                              got.stray, want.stray));
                if (got.was_stray !== want.was_stray)
                    report_mismatch($sformatf("was_stray got %0b expected %0b",
                                              got.was_stray, want.was_stray));
            end
            results_checked++;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, expected_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        stim_row_t                      row;
        logic                           op;
        logic [psh_pkg::PC_W-1:0]       pc;
        logic [psh_pkg::READ_BIN_W-1:0] rbin;
        logic [psh_pkg::READ_BIN_W-1:0] hot_bin;
        longint unsigned reach;
        longint unsigned span;
        longint unsigned off;
        int unsigned     pick_lim;
        int unsigned     b;
        int unsigned     kind;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = psh_pkg::REG_BASE;
        cfg_data             = '0;
        sample_ch.valid      = 1'b0;
        sample_ch.operation  = psh_pkg::OP_RECORD;
        sample_ch.sampled_pc = '0;
        sample_ch.read_bin   = '0;
        result_ch.ready      = 1'b0;
        idle_on              = 1'b0;
        stall_left           = 0;
        error_count          = 0;
        words_sent           = 0;
        reads_sent           = 0;
        strays_seen          = 0;
        results_checked      = 0;
        cfg_writes           = 0;
        hot_bin              = '0;

        foreach (bin_counts[i])
            bin_counts[i] = '0;
        sample_count  = '0;
        stray_count   = '0;
        cfg_base      = '0;
        cfg_gran      = psh_pkg::GRAN_RESET;
        cfg_bin_limit = psh_pkg::BINS_RESET;

        directed_rows = '{
            typed_row(psh_pkg::OP_READ,   32'h0,        12'd0,    32'd0, 32'd0, 32'd0, 1'b0),
            typed_row(psh_pkg::OP_READ,   32'h0,        12'd4095, 32'd0, 32'd0, 32'd0, 1'b0),
            typed_row(psh_pkg::OP_RECORD, 32'h0,        12'd0,    32'd1, 32'd1, 32'd0, 1'b0),
            typed_row(psh_pkg::OP_RECORD, 32'h0000FFFF, 12'd0,    32'd1, 32'd2, 32'd0, 1'b0),
            typed_row(psh_pkg::OP_RECORD, 32'h00010000, 12'd0,    32'd0, 32'd3, 32'd1, 1'b1),
            typed_row(psh_pkg::OP_RECORD, 32'hFFFFFFFF, 12'hFFF,  32'd0, 32'd4, 32'd2, 1'b1),
            typed_row(psh_pkg::OP_READ,   32'hFFFFFFFF, 12'd0,    32'd1, 32'd4, 32'd2, 1'b0),
            typed_row(psh_pkg::OP_READ,   32'h0,        12'd4095, 32'd1, 32'd4, 32'd2, 1'b0),
            cfg_row(psh_pkg::REG_BASE, 32'hFFFFFFF0),
            word_row(psh_pkg::OP_RECORD, 32'h00000005, 12'd0),
            word_row(psh_pkg::OP_RECORD, 32'h0000000F, 12'd0),
            word_row(psh_pkg::OP_RECORD, 32'hFFFFFFEF, 12'd0),
            cfg_row(psh_pkg::REG_GRAN, 32'd1),
            word_row(psh_pkg::OP_RECORD, 32'h00000FEF, 12'd0),
            cfg_row(psh_pkg::REG_GRAN, 32'd0),
            word_row(psh_pkg::OP_RECORD, 32'hFFFFFFF0, 12'd0),
            cfg_row(psh_pkg::REG_BASE, 32'h0),
            cfg_row(psh_pkg::REG_GRAN, 32'hFFFFFFFF),
            word_row(psh_pkg::OP_RECORD, 32'hFFFFFFFF, 12'd0),
            word_row(psh_pkg::OP_RECORD, 32'hFFFFFFFE, 12'd0),
            cfg_row(psh_pkg::REG_BINS, 32'd0),
            word_row(psh_pkg::OP_RECORD, 32'h0, 12'd0),
            cfg_row(psh_pkg::REG_GRAN, 32'd1),
            cfg_row(psh_pkg::REG_BINS, 32'h00001FFF),
            word_row(psh_pkg::OP_RECORD, 32'd4095, 12'd0),
            word_row(psh_pkg::OP_RECORD, 32'd4096, 12'd0),
            cfg_row(REG_NONE, 32'h12345678),
            word_row(psh_pkg::OP_RECORD, 32'd4095, 12'd0),
            cfg_row(psh_pkg::REG_BINS, 32'd1),
            word_row(psh_pkg::OP_RECORD, 32'd4095, 12'd0),
            word_row(psh_pkg::OP_READ,   32'h0, 12'd4095),
            cfg_row(psh_pkg::REG_BINS, 32'hFFFFF000),
            word_row(psh_pkg::OP_RECORD, 32'h00000123, 12'd0),
            word_row(psh_pkg::OP_READ,   32'h0, 12'h123)
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words run with no idling on either side.
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
            begin
                quiesce();
                write_reg(row.reg_idx, row.reg_data);
            end
            else
            begin
                send_word(row.op, row.pc, row.rbin, row.typed, row.exp_result);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            quiesce();
            idle_on <= (p != 0);
            case (p)
                0:
                begin
                    write_reg(psh_pkg::REG_BASE, 32'h0);
                    write_reg(psh_pkg::REG_GRAN, psh_pkg::GRAN_RESET);
                    write_reg(psh_pkg::REG_BINS, 32'(psh_pkg::BINS_RESET));
                end
                1:
                begin
                    write_reg(psh_pkg::REG_BASE, $urandom);
                    write_reg(psh_pkg::REG_GRAN, 32'd1 << $urandom_range(0, 12));
                    write_reg(psh_pkg::REG_BINS, $urandom_range(1, NUM_BINS));
                end
                2:
                begin
                    write_reg(psh_pkg::REG_BASE, 32'hFFFFFFFF - $urandom_range(0, 1 << 20));
                    write_reg(psh_pkg::REG_GRAN, 32'd1);
                    write_reg(psh_pkg::REG_BINS, 32'h1FFF);
                end
                3:
                begin
                    write_reg(psh_pkg::REG_BASE, $urandom);
                    write_reg(psh_pkg::REG_GRAN, $urandom_range(1, 100));
                    write_reg(psh_pkg::REG_BINS, $urandom_range(1, 16));
                end
                4:
                begin
                    write_reg(psh_pkg::REG_BASE, $urandom);
                    write_reg(psh_pkg::REG_GRAN, $urandom | 32'h1);
                    write_reg(psh_pkg::REG_BINS, 32'(psh_pkg::BINS_RESET));
                end
                default:
                begin
                    write_reg(REG_NONE, $urandom);
                    write_reg(psh_pkg::REG_BASE, $urandom);
                    write_reg(psh_pkg::REG_GRAN, ($urandom_range(0, 3) == 0) ? 32'd0 :
                                                 $urandom_range(1, 4096));
                    write_reg(psh_pkg::REG_BINS, $urandom);
                end
            endcase

            // Number of bins that an aimed address can land in under this configuration.
            if (cfg_gran == '0 || cfg_bin_limit == '0)
            begin
                reach = 0;
            end
            else
            begin
                span  = 64'hFFFFFFFF / cfg_gran + 1;
                reach = (cfg_bin_limit > NUM_BINS) ? NUM_BINS : cfg_bin_limit;
                if (span < reach)
                    reach = span;
            end
            pick_lim = 32'(reach);

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                kind = $urandom_range(0, 99);
                pc   = $urandom;
                rbin = psh_pkg::READ_BIN_W'($urandom);
                if (kind < 30)
                begin
                    op = psh_pkg::OP_READ;
                    if ($urandom_range(0, 1) == 1)
                        rbin = hot_bin;
                end
                else
                begin
                    op = psh_pkg::OP_RECORD;
                    if (kind < 85 && pick_lim != 0)
                    begin
                        if ($urandom_range(0, 1) == 1)
                            b = $urandom_range(0, ((pick_lim > 8) ? 8 : pick_lim) - 1);
                        else
                            b = $urandom_range(0, pick_lim - 1);
                        off = longint'(b) * cfg_gran + ($urandom % cfg_gran);
                        if (off > 64'hFFFFFFFF)
                            off = 64'hFFFFFFFF;
                        pc      = cfg_base + off[31:0];
                        hot_bin = b[psh_pkg::READ_BIN_W-1:0];
                    end
                end
                send_word(op, pc, rbin, 1'b0, '0);
            end
        end

        quiesce();
        repeat (END_TAIL) @(posedge clk);

        $display("Sent %0d sample words (%0d reads) under %0d register writes.",
                 words_sent, reads_sent, cfg_writes);
        $display("Checked %0d result words, %0d of them stray records, in %0d cycles.",
                 results_checked, strays_seen, cycle_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
